// ===== hdl/circle_quadrant_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// circle_quadrant_rasterizer_assert.svh
// assertion macros for the quadrant rasterizer, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef CIRCLE_QUADRANT_RASTERIZER_ASSERT_SVH
`define CIRCLE_QUADRANT_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

// property that holds in every cycle out of reset
`define CQR_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cqr assertion failed");

// consequent checked in the cycle after the antecedent
`define CQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cqr assertion failed");

`else

`define CQR_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define CQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/cqr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqr_pkg
// types, codes and helpers of the circle quadrant rasterizer
// ----------------------------------------------------------------------------
package cqr_pkg;

  // item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // quadrant codes
  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  // rgb565 field masks and shifts
  localparam logic [15:0] FIELD5_MASK = 16'h001f;
  localparam logic [15:0] LOW11_MASK  = 16'h07ff;
  localparam int unsigned RED_SHIFT   = 11;
  localparam int unsigned GREEN_SHIFT = 5;

  // one span of output, colour kept per pair
  typedef struct packed {
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic [7:0]        len;
    logic              last;
  } span_t;

  // swap the red and blue fields of an rgb565 colour
  function automatic logic [15:0] swap_rb(input logic [15:0] c);
    logic [15:0] red;
    logic [15:0] blue;
    logic [15:0] green;
    red   = (c >> RED_SHIFT) & FIELD5_MASK;
    blue  = c & FIELD5_MASK;
    green = (c & LOW11_MASK) >> GREEN_SHIFT;
    return red | (green << GREEN_SHIFT) | (blue << RED_SHIFT);
  endfunction

endpackage

// ===== hdl/circle_quadrant_rasterizer.sv =====
`timescale 1ns / 1ps
// A step's first span is valid the cycle after acceptance, its second once the first is taken.
// A step can enter as the last one's second span leaves; both share the single result port.
// Start items give no span and face the same input stall as step items.
// Reset (rst_n low, synchronous) empties the span buffer and leaves the block idle.
// ----------------------------------------------------------------------------
// circle_quadrant_rasterizer
// midpoint circle rasterizer for one quadrant, two spans per step item
// ----------------------------------------------------------------------------
`include "circle_quadrant_rasterizer_assert.svh"

module circle_quadrant_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [7:0]         in_center_x,
  input  logic [7:0]         in_center_y,
  input  logic [7:0]         in_radius,
  input  logic [1:0]         in_corner,
  input  logic               in_fill_mode,
  input  logic [15:0]        in_pixel_color,
  // span output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [9:0]  out_span_x,
  output logic signed [9:0]  out_span_y,
  output logic [7:0]         out_span_length,
  output logic [15:0]        out_color,
  output logic               out_last
);

  // rasterizer state
  logic [7:0]         ctr_x_r;
  logic [7:0]         ctr_y_r;
  logic [1:0]         quadrant_r;
  logic               filled_r;
  logic [15:0]        color_r;
  logic signed [11:0] decision_r;
  logic [9:0]         step_x_incr_r;
  logic signed [10:0] step_y_incr_r;
  logic [7:0]         pos_x_r;
  logic [7:0]         pos_y_r;
  logic               running_r;

  // span buffer
  cqr_pkg::span_t     span0_r;
  cqr_pkg::span_t     span1_r;
  logic [15:0]        pair_color_r;
  logic [1:0]         count_r;
  logic [1:0]         count_nxt;

  // step results
  logic               in_accept;
  logic               out_accept;
  logic               is_start;
  logic               load;
  logic               d_ge;
  logic [7:0]         y1;
  logic [7:0]         x1;
  logic signed [10:0] syi1;
  logic signed [11:0] dec1;
  logic signed [11:0] dec2;
  logic [9:0]         sxi1;
  logic               last_nxt;
  logic [9:0]         cx;
  logic [9:0]         cy;
  logic [9:0]         xx;
  logic [9:0]         yy;
  cqr_pkg::span_t     span0_nxt;
  cqr_pkg::span_t     span1_nxt;

  // handshake
  assign in_stall   = (count_r == 2'd2) || ((count_r == 2'd1) && out_stall);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (count_r != 2'd0);
  assign out_accept = out_valid && !out_stall;
  assign is_start   = (in_opcode == cqr_pkg::OP_START);
  assign load       = in_accept && (in_opcode == cqr_pkg::OP_STEP) && running_r;

  // one midpoint step
  always_comb begin
    d_ge     = !decision_r[11];
    y1       = d_ge ? (pos_y_r - 8'd1) : pos_y_r;
    syi1     = d_ge ? (step_y_incr_r + 11'sd2) : step_y_incr_r;
    dec1     = d_ge ? (decision_r + 12'(syi1)) : decision_r;
    x1       = pos_x_r + 8'd1;
    sxi1     = step_x_incr_r + 10'd2;
    dec2     = dec1 + $signed({2'b00, sxi1});
    last_nxt = (x1 >= y1);
  end

  // span coordinates for the chosen quadrant and mode
  always_comb begin
    cx = {2'b00, ctr_x_r};
    cy = {2'b00, ctr_y_r};
    xx = {2'b00, x1};
    yy = {2'b00, y1};
    span0_nxt.last = 1'b0;
    span1_nxt.last = last_nxt;
    if (filled_r) begin
      case (cqr_pkg::corner_t'(quadrant_r))
        cqr_pkg::CORNER_TL: begin
          span0_nxt.x = cx - xx;  span0_nxt.y = cy - yy;  span0_nxt.len = x1;
          span1_nxt.x = cx - yy;  span1_nxt.y = cy - xx;  span1_nxt.len = y1;
        end
        cqr_pkg::CORNER_TR: begin
          span0_nxt.x = cx;       span0_nxt.y = cy - yy;  span0_nxt.len = x1;
          span1_nxt.x = cx;       span1_nxt.y = cy - xx;  span1_nxt.len = y1;
        end
        cqr_pkg::CORNER_BL: begin
          span0_nxt.x = cx - yy;  span0_nxt.y = cy + xx;  span0_nxt.len = y1;
          span1_nxt.x = cx - xx;  span1_nxt.y = cy + yy;  span1_nxt.len = x1;
        end
        default: begin
          span0_nxt.x = cx;       span0_nxt.y = cy + xx;  span0_nxt.len = y1;
          span1_nxt.x = cx;       span1_nxt.y = cy + yy;  span1_nxt.len = x1;
        end
      endcase
    end else begin
      span0_nxt.len = 8'd1;
      span1_nxt.len = 8'd1;
      case (cqr_pkg::corner_t'(quadrant_r))
        cqr_pkg::CORNER_TL: begin
          span0_nxt.x = cx - yy;  span0_nxt.y = cy - xx;
          span1_nxt.x = cx - xx;  span1_nxt.y = cy - yy;
        end
        cqr_pkg::CORNER_TR: begin
          span0_nxt.x = cx + xx;  span0_nxt.y = cy - yy;
          span1_nxt.x = cx + yy;  span1_nxt.y = cy - xx;
        end
        cqr_pkg::CORNER_BL: begin
          span0_nxt.x = cx - xx;  span0_nxt.y = cy + yy;
          span1_nxt.x = cx - yy;  span1_nxt.y = cy + xx;
        end
        default: begin
          span0_nxt.x = cx + xx;  span0_nxt.y = cy + yy;
          span1_nxt.x = cx + yy;  span1_nxt.y = cy + xx;
        end
      endcase
    end
  end

  // buffer fill count
  always_comb begin
    if (load) begin
      count_nxt = 2'd2;
    end else if (out_accept) begin
      count_nxt = count_r - 2'd1;
    end else begin
      count_nxt = count_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 2'd0;
      running_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_accept && is_start) begin
        running_r <= (in_radius != 8'd0);
      end else if (load) begin
        running_r <= !last_nxt;
      end
    end
  end

  // rasterizer state registers
  always_ff @(posedge clk) begin
    if (in_accept && is_start) begin
      ctr_x_r       <= in_center_x;
      ctr_y_r       <= in_center_y;
      quadrant_r    <= in_corner;
      filled_r      <= in_fill_mode;
      color_r       <= cqr_pkg::swap_rb(in_pixel_color);
      decision_r    <= 12'sd1 - $signed({4'b0000, in_radius});
      step_x_incr_r <= 10'd1;
      step_y_incr_r <= -$signed({2'b00, in_radius, 1'b0});
      pos_x_r       <= 8'd0;
      pos_y_r       <= in_radius;
    end else if (load) begin
      decision_r    <= dec2;
      step_x_incr_r <= sxi1;
      step_y_incr_r <= syi1;
      pos_x_r       <= x1;
      pos_y_r       <= y1;
    end
  end

  // span buffer payload
  always_ff @(posedge clk) begin
    if (load) begin
      span0_r      <= span0_nxt;
      span1_r      <= span1_nxt;
      pair_color_r <= color_r;
    end
  end

  // output select: first span while two are held
  always_comb begin
    if (count_r == 2'd2) begin
      out_span_x      = span0_r.x;
      out_span_y      = span0_r.y;
      out_span_length = span0_r.len;
      out_last        = span0_r.last;
    end else begin
      out_span_x      = span1_r.x;
      out_span_y      = span1_r.y;
      out_span_length = span1_r.len;
      out_last        = span1_r.last;
    end
    out_color = pair_color_r;
  end

  // assertions
  `CQR_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r != 2'd3)
  `CQR_ASSERT_ALWAYS(a_last_second, clk, rst_n, !(out_valid && out_last && (count_r != 2'd1)))
  `CQR_ASSERT_NEXT(a_load_fills, clk, rst_n, load, count_r == 2'd2)
  `CQR_ASSERT_NEXT(a_last_idles, clk, rst_n, load && last_nxt, !running_r)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circle quadrant rasterizer. A scoreboard runs
// its own midpoint stepper on every accepted item and queues the two spans
// that each step should produce. Every accepted span is checked field by
// field against the oldest queued one. Directed quadrants cover the corner
// cases. Random quadrants with random stalls and gaps on both sides follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS   = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // one expected span, colour included
  typedef struct {
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic [7:0]        len;
    logic [15:0]       color;
    logic              last;
  } exp_span_t;

  // quadrant stepper plus the queue of spans still owed by the block
  class span_scoreboard;
    logic [7:0]         ctr_x = '0;
    logic [7:0]         ctr_y = '0;
    cqr_pkg::corner_t   quadrant = cqr_pkg::CORNER_TL;
    logic               filled = 1'b0;
    logic [15:0]        color = '0;
    logic signed [11:0] decision = '0;
    logic [9:0]         x_incr = '0;
    logic signed [10:0] y_incr = '0;
    logic [7:0]         pos_x = '0;
    logic [7:0]         pos_y = '0;
    bit                 running = 1'b0;
    exp_span_t          owed_spans[$];
    int                 errors = 0;

    function void push_span(int sx, int sy, int len, bit lst);
      exp_span_t s;
      s.x     = sx[9:0];
      s.y     = sy[9:0];
      s.len   = len[7:0];
      s.color = color;
      s.last  = lst;
      owed_spans.push_back(s);
    endfunction

    // advance the stepper on an accepted item and queue its spans
    function void note_item(logic op, logic [7:0] cx, logic [7:0] cy, logic [7:0] r,
                            logic [1:0] cor, logic fm, logic [15:0] pc);
      int cxi;
      int cyi;
      int xi;
      int yi;
      bit lst;
      if (op == cqr_pkg::OP_START) begin
        ctr_x    = cx;
        ctr_y    = cy;
        quadrant = cqr_pkg::corner_t'(cor);
        filled   = fm;
        // red and blue trade places, green stays
        color    = {pc[4:0], pc[10:5], pc[15:11]};
        decision = 12'sd1 - $signed({4'b0000, r});
        x_incr   = 10'd1;
        y_incr   = 11'sd0 - $signed({2'b00, r, 1'b0});
        pos_x    = '0;
        pos_y    = r;
        running  = (pos_x < pos_y);
        return;
      end
      if (!running) return;

      // midpoint decision update
      if (decision >= 0) begin
        pos_y    = pos_y - 8'd1;
        y_incr   = y_incr + 11'sd2;
        decision = decision + y_incr;
      end
      pos_x    = pos_x + 8'd1;
      x_incr   = x_incr + 10'd2;
      decision = decision + $signed({2'b00, x_incr});

      cxi = ctr_x;
      cyi = ctr_y;
      xi  = pos_x;
      yi  = pos_y;
      lst = (pos_x >= pos_y);
      running = !lst;

      if (filled) begin
        case (quadrant)
          cqr_pkg::CORNER_TL: begin
            push_span(cxi - xi, cyi - yi, xi, 1'b0);
            push_span(cxi - yi, cyi - xi, yi, lst);
          end
          cqr_pkg::CORNER_TR: begin
            push_span(cxi, cyi - yi, xi, 1'b0);
            push_span(cxi, cyi - xi, yi, lst);
          end
          cqr_pkg::CORNER_BL: begin
            push_span(cxi - yi, cyi + xi, yi, 1'b0);
            push_span(cxi - xi, cyi + yi, xi, lst);
          end
          default: begin
            push_span(cxi, cyi + xi, yi, 1'b0);
            push_span(cxi, cyi + yi, xi, lst);
          end
        endcase
      end else begin
        case (quadrant)
          cqr_pkg::CORNER_TL: begin
            push_span(cxi - yi, cyi - xi, 1, 1'b0);
            push_span(cxi - xi, cyi - yi, 1, lst);
          end
          cqr_pkg::CORNER_TR: begin
            push_span(cxi + xi, cyi - yi, 1, 1'b0);
            push_span(cxi + yi, cyi - xi, 1, lst);
          end
          cqr_pkg::CORNER_BL: begin
            push_span(cxi - xi, cyi + yi, 1, 1'b0);
            push_span(cxi - yi, cyi + xi, 1, lst);
          end
          default: begin
            push_span(cxi + xi, cyi + yi, 1, 1'b0);
            push_span(cxi + yi, cyi + xi, 1, lst);
          end
        endcase
      end
    endfunction

    // compare one accepted span with the oldest owed one
    function void check_span(logic signed [9:0] sx, logic signed [9:0] sy, logic [7:0] len,
                             logic [15:0] col, logic lst);
      exp_span_t e;
      if (owed_spans.size() == 0) begin
        $error("unexpected span: x %0d y %0d length %0d", sx, sy, len);
        errors++;
        return;
      end
      e = owed_spans.pop_front();
      if (sx !== e.x) begin
        $error("span_x mismatch: expected %0d, actual %0d", e.x, sx);
        errors++;
      end
      if (sy !== e.y) begin
        $error("span_y mismatch: expected %0d, actual %0d", e.y, sy);
        errors++;
      end
      if (len !== e.len) begin
        $error("span_length mismatch: expected %0d, actual %0d", e.len, len);
        errors++;
      end
      if (col !== e.color) begin
        $error("out_color mismatch: expected %h, actual %h", e.color, col);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last mismatch: expected %0d, actual %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = cqr_pkg::OP_START;
  logic [7:0]         in_center_x = '0;
  logic [7:0]         in_center_y = '0;
  logic [7:0]         in_radius = '0;
  logic [1:0]         in_corner = '0;
  logic               in_fill_mode = 1'b0;
  logic [15:0]        in_pixel_color = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [9:0]  out_span_x;
  logic signed [9:0]  out_span_y;
  logic [7:0]         out_span_length;
  logic [15:0]        out_color;
  logic               out_last;

  span_scoreboard sb = new;
  int  items_sent = 0;
  int  gap_pct = 0;
  int  stall_pct = 0;
  int  stall_left = 0;
  int  cycle_cnt = 0;
  int  quiet_cycles = 0;
  bit  quiet = 1'b0;

  circle_quadrant_rasterizer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_corner       (in_corner),
    .in_fill_mode    (in_fill_mode),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_length (out_span_length),
    .out_color       (out_color),
    .out_last        (out_last)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // drive one item until accepted, then maybe leave a gap
  task automatic send_item(input logic op, input logic [7:0] cx, input logic [7:0] cy,
                           input logic [7:0] r, input logic [1:0] cor, input logic fm,
                           input logic [15:0] pc);
    bit counted;
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_center_x    <= cx;
    in_center_y    <= cy;
    in_radius      <= r;
    in_corner      <= cor;
    in_fill_mode   <= fm;
    in_pixel_color <= pc;
    do @(posedge clk); while (in_stall);
    // steps while idle are ignored by the block and not counted
    counted = (op == cqr_pkg::OP_START) || sb.running;
    sb.note_item(op, cx, cy, r, cor, fm, pc);
    if (counted) items_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // step item, other fields are don't-care so send junk
  task automatic send_step();
    send_item(cqr_pkg::OP_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
              1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_step();
  endtask

  // hold the sender off until every owed span has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_spans.size() != 0) @(posedge clk);
  endtask

  // result side stall bursts
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt % 256 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 8;
        default: stall_pct = 30;
      endcase
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 13);
    end
    out_stall <= (stall_left != 0);
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_span(out_span_x, out_span_y, out_span_length, out_color, out_last);
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int r;
    int abort_at;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // step straight out of reset, nothing running
    send_step();
    // zero radius stays idle, the following step is ignored
    send_item(cqr_pkg::OP_START, 8'd255, 8'd255, 8'd0, cqr_pkg::CORNER_BR, 1'b1, 16'hffff);
    send_step();
    // radius one finishes on its first step, negative coordinates
    send_item(cqr_pkg::OP_START, 8'd0, 8'd0, 8'd1, cqr_pkg::CORNER_TL, 1'b0, 16'h0000);
    send_steps(2);
    // largest radius, cut short by a restart while still running
    send_item(cqr_pkg::OP_START, 8'd0, 8'd255, 8'd255, cqr_pkg::CORNER_TR, 1'b1, 16'hf800);
    send_steps(2);
    send_item(cqr_pkg::OP_START, 8'd255, 8'd0, 8'd2, cqr_pkg::CORNER_BL, 1'b1, 16'h001f);
    send_steps(2);
    send_item(cqr_pkg::OP_START, 8'd128, 8'd128, 8'd3, cqr_pkg::CORNER_BR, 1'b0, 16'h07e0);
    send_steps(3);
    send_item(cqr_pkg::OP_START, 8'd255, 8'd0, 8'd255, cqr_pkg::CORNER_BL, 1'b0, 16'ha5a5);
    send_step();
    send_item(cqr_pkg::OP_START, 8'd7, 8'd200, 8'd4, cqr_pkg::CORNER_TL, 1'b1, 16'h5a5a);
    send_steps(2);
    wait_drained();

    // random quadrants, mostly run to completion
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent % 100 < 3) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
      end
      if ($urandom_range(0, 99) < 4) begin
        send_step();
      end else begin
        n = $urandom_range(0, 99);
        if (n < 70) r = $urandom_range(0, 20);
        else if (n < 95) r = $urandom_range(21, 100);
        else r = $urandom_range(101, 255);
        send_item(cqr_pkg::OP_START, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'(r),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)));
        // some quadrants are broken off by the next start
        abort_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 5) : -1;
        n = 0;
        while (sb.running && n != abort_at) begin
          send_step();
          n++;
        end
      end
      if (!quiet && $urandom_range(0, 19) == 0) wait_drained();
      if (items_sent > RANDOM_ITEMS * 17 / 20) quiet = 1'b1;
    end

    // drain and settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cqr_pkg.sv
hdl/circle_quadrant_rasterizer.sv
dv/tb_top.sv
